FILE: design/substring_match_locator_unit_macros.svh
// Assertion macros for the substring match locator.
`ifndef SUBSTRING_MATCH_LOCATOR_UNIT_MACROS_SVH
`define SUBSTRING_MATCH_LOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check that the consequent holds in the same cycle as the antecedent.
`define SML_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define SML_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SML_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define SML_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: design/sml_pkg.sv
// Shared constants, codes and types of the substring match locator.
`timescale 1ns / 1ps

package sml_pkg;

   localparam int PATTERN_MAX    = 16;
   localparam int POSITION_BITS  = 24;
   localparam int COUNT_BITS     = 16;
   localparam int BYTE_BITS      = 8;
   localparam int LEN_BITS       = 5;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 2;
   localparam int FILL_BITS      = $clog2(PATTERN_MAX + 1);
   localparam int IDX_BITS       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
   localparam logic [COUNT_BITS-1:0]    COUNT_MAX = '1;

   // byte range 0x80 to 0xC2 that leaves the character position alone
   localparam logic [BYTE_BITS-1:0] CONT_LOW  = 8'h80;
   localparam logic [BYTE_BITS-1:0] CONT_HIGH = 8'hC2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_PATTERN_LEN  = 2'd2
   } csr_index_type;

   typedef enum logic {
      RESULT_MATCH = 1'b0,
      RESULT_COUNT = 1'b1
   } result_kind_type;

   typedef logic [PATTERN_MAX-1:0][BYTE_BITS-1:0] pattern_bytes_type;

   typedef struct packed {
      result_kind_type          result_kind;
      logic [POSITION_BITS-1:0] match_start;
      logic [POSITION_BITS-1:0] match_end;
      logic [COUNT_BITS-1:0]    match_total;
      logic                     last_of_run;
   } result_type;

   typedef struct packed {
      logic [PATTERN_MAX-1:0][BYTE_BITS-1:0]     bytes;
      logic [PATTERN_MAX-1:0][POSITION_BITS-1:0] positions;
      logic [FILL_BITS-1:0]                      fill;
   } window_view_type;

   typedef struct packed {
      logic       hit;
      logic       end_of_text;
      result_type match_res;
      result_type count_res;
   } step_type;

endpackage

FILE: design/sml_if.sv
// Stream channel interfaces for text bytes in and located results out.
`timescale 1ns / 1ps

interface sml_req_if;
   import sml_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] text_byte;
   logic                 end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface sml_rsp_if;
   import sml_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     result_kind;
   logic [POSITION_BITS-1:0] match_start;
   logic [POSITION_BITS-1:0] match_end;
   logic [COUNT_BITS-1:0]    match_total;
   logic                     last_of_run;

   modport source (output valid, output result_kind, output match_start, output match_end,
                   output match_total, output last_of_run, input ready);
   modport sink   (input valid, input result_kind, input match_start, input match_end,
                   input match_total, input last_of_run, output ready);
endinterface

FILE: design/sml_window.sv
// Byte and position window with the character position counter.
`timescale 1ns / 1ps

module sml_window (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fire,
   input  logic [sml_pkg::BYTE_BITS-1:0]     text_byte,
   input  logic                              end_of_text,
   output sml_pkg::window_view_type          view
);
   import sml_pkg::*;

   logic [PATTERN_MAX-1:0][BYTE_BITS-1:0]     bytes_ff, bytes_in;
   logic [PATTERN_MAX-1:0][POSITION_BITS-1:0] positions_ff, positions_in;
   logic [FILL_BITS-1:0]                      fill_ff, fill_in;
   logic [POSITION_BITS-1:0]                  pos_ff, pos_in;
   logic                                      cont;

   assign cont = (text_byte >= CONT_LOW) && (text_byte <= CONT_HIGH);

   always_comb begin
      pos_in = ((!cont) && (pos_ff != POS_MAX)) ? pos_ff + POSITION_BITS'(1) : pos_ff;
      fill_in = (fill_ff != FILL_BITS'(PATTERN_MAX)) ? fill_ff + FILL_BITS'(1) : fill_ff;
      bytes_in[0] = text_byte;
      positions_in[0] = pos_in;
      for (int j = 1; j < PATTERN_MAX; j++) begin
         bytes_in[j] = bytes_ff[j-1];
         positions_in[j] = positions_ff[j-1];
      end
   end

   assign view.bytes     = bytes_in;
   assign view.positions = positions_in;
   assign view.fill      = fill_in;

   // entries beyond the fill count are never compared, so they need no reset
   always_ff @(posedge clock) begin
      if (fire) begin
         bytes_ff <= bytes_in;
         positions_ff <= positions_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pos_ff <= '0;
      end else if (fire) begin
         fill_ff <= end_of_text ? '0 : fill_in;
         pos_ff <= end_of_text ? '0 : pos_in;
      end
   end

endmodule

FILE: design/sml_match.sv
// Parallel pattern compare, match counter and result formation.
`timescale 1ns / 1ps

module sml_match (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire,
   input  logic                           end_of_text,
   input  sml_pkg::window_view_type       view,
   input  sml_pkg::pattern_bytes_type     pattern,
   input  logic [sml_pkg::LEN_BITS-1:0]   pattern_len,
   output sml_pkg::step_type              step
);
   import sml_pkg::*;

   logic [LEN_BITS-1:0]        plen;
   logic [LEN_BITS-1:0]        start_idx;
   logic                       hit;
   logic [POSITION_BITS-1:0]   start_pos;
   logic [POSITION_BITS:0]     end_sum;
   logic [POSITION_BITS-1:0]   end_pos;
   logic [COUNT_BITS-1:0]      count_ff, count_in;

   assign plen = (pattern_len > LEN_BITS'(PATTERN_MAX)) ? LEN_BITS'(PATTERN_MAX) : pattern_len;

   // align pattern byte plen-1-j with window entry j (newest byte in entry 0)
   always_comb begin
      logic [LEN_BITS-1:0] sel;
      hit = (plen != '0) && (LEN_BITS'(view.fill) >= plen);
      sel = '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         if (LEN_BITS'(j) < plen) begin
            sel = plen - LEN_BITS'(j) - LEN_BITS'(1);
            if (view.bytes[j] != pattern[sel[IDX_BITS-1:0]]) begin
               hit = 1'b0;
            end
         end
      end
   end

   assign start_idx = plen - LEN_BITS'(1);
   assign start_pos = view.positions[start_idx[IDX_BITS-1:0]];
   assign end_sum   = {1'b0, start_pos} + (POSITION_BITS + 1)'(start_idx);
   assign end_pos   = (end_sum > {1'b0, POS_MAX}) ? POS_MAX : end_sum[POSITION_BITS-1:0];

   assign count_in = (hit && (count_ff != COUNT_MAX)) ? count_ff + COUNT_BITS'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (fire) begin
         count_ff <= end_of_text ? '0 : count_in;
      end
   end

   always_comb begin
      step.hit = hit;
      step.end_of_text = end_of_text;
      step.match_res.result_kind = RESULT_MATCH;
      step.match_res.match_start = start_pos;
      step.match_res.match_end   = end_pos;
      step.match_res.match_total = count_in;
      step.match_res.last_of_run = !end_of_text;
      step.count_res.result_kind = RESULT_COUNT;
      step.count_res.match_start = '0;
      step.count_res.match_end   = '0;
      step.count_res.match_total = count_in;
      step.count_res.last_of_run = 1'b1;
   end

endmodule

FILE: design/sml_result.sv
// Output register with one pending slot for the second result of a beat.
`timescale 1ns / 1ps

module sml_result (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  sml_pkg::step_type     step,
   input  logic                  take,
   output logic                  accept_ok,
   output logic                  out_valid,
   output sml_pkg::result_type   out_result
);
   import sml_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       pend_valid_ff, pend_valid_in;
   result_type out_ff, out_in;
   result_type pend_ff, pend_in;

   assign accept_ok = (!pend_valid_ff) && ((!out_valid_ff) || take);

   always_comb begin
      out_valid_in = out_valid_ff;
      pend_valid_in = pend_valid_ff;
      out_in = out_ff;
      pend_in = pend_ff;
      if (fire) begin
         // the output slot is free or drains this cycle
         if (step.hit) begin
            out_valid_in = 1'b1;
            out_in = step.match_res;
            pend_valid_in = step.end_of_text;
            pend_in = step.count_res;
         end else if (step.end_of_text) begin
            out_valid_in = 1'b1;
            out_in = step.count_res;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (out_valid_ff && take) begin
         if (pend_valid_ff) begin
            out_in = pend_ff;
            pend_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      pend_ff <= pend_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

endmodule

FILE: design/substring_match_locator_unit.sv
// Top level of the substring match locator: windowed pattern search on a byte stream.
// A result is registered and appears in the cycle after the beat that causes it.
// Throughput: one text byte per cycle while the sink takes results, set by the combinational window compare;
// a final byte that also completes a match gives two results and holds input while the count result waits.
// Reset (synchronous, active high) empties the window and output, zeroes counters, pattern 0, length 1.
`timescale 1ns / 1ps
`include "substring_match_locator_unit_macros.svh"

module substring_match_locator_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   sml_req_if.sink                               req_channel,
   sml_rsp_if.source                             rsp_channel,
   input  logic                                  csr_write_enable,
   input  logic [sml_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sml_pkg::CSR_DATA_BITS-1:0]     csr_write_data
);
   import sml_pkg::*;

   // Configuration registers
   logic [CSR_DATA_BITS-1:0] pattern_low_ff;
   logic [CSR_DATA_BITS-1:0] pattern_high_ff;
   logic [LEN_BITS-1:0]      pattern_len_ff;

   pattern_bytes_type pattern;
   window_view_type   view;
   step_type          step;
   result_type        out_result;
   logic              accept_ok;
   logic              out_valid;
   logic              fire;

   // Take a write at once; an index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff <= '0;
         pattern_high_ff <= '0;
         pattern_len_ff <= LEN_BITS'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  pattern_low_ff <= csr_write_data;
            CSR_PATTERN_HIGH: pattern_high_ff <= csr_write_data;
            CSR_PATTERN_LEN:  pattern_len_ff <= csr_write_data[LEN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Unpack the pattern words into bytes, byte 0 in the lowest bits of the low word
   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if (k < 8) begin
            pattern[k] = pattern_low_ff[k*BYTE_BITS +: BYTE_BITS];
         end else begin
            pattern[k] = pattern_high_ff[(k-8)*BYTE_BITS +: BYTE_BITS];
         end
      end
   end

   // A beat enters when the output slot frees up and no second result waits
   assign req_channel.ready = accept_ok;
   assign fire = req_channel.valid && accept_ok;

   // Shift the new byte and its character position into the window
   sml_window u_window (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .text_byte   (req_channel.text_byte),
      .end_of_text (req_channel.end_of_text),
      .view        (view)
   );

   // Compare the window tail with the pattern and form both possible results
   sml_match u_match (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .end_of_text (req_channel.end_of_text),
      .view        (view),
      .pattern     (pattern),
      .pattern_len (pattern_len_ff),
      .step        (step)
   );

   // Hold results for the sink; the count result of a final byte queues behind its match
   sml_result u_result (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .step       (step),
      .take       (rsp_channel.ready),
      .accept_ok  (accept_ok),
      .out_valid  (out_valid),
      .out_result (out_result)
   );

   assign rsp_channel.valid       = out_valid;
   assign rsp_channel.result_kind = out_result.result_kind;
   assign rsp_channel.match_start = out_result.match_start;
   assign rsp_channel.match_end   = out_result.match_end;
   assign rsp_channel.match_total = out_result.match_total;
   assign rsp_channel.last_of_run = out_result.last_of_run;

   // A beat is taken over a waiting result only while that result drains
   `SML_ASSERT_IMPL(a_accept_drains_output, clock, reset, req_channel.valid && req_channel.ready && rsp_channel.valid, rsp_channel.ready, "input beat taken over a stalled result")

   // The final byte of a text always produces a result next cycle
   `SML_ASSERT_NEXT(a_end_gives_result, clock, reset, fire && req_channel.end_of_text, rsp_channel.valid, "no result after end of text")

   // A match that is not last of its run has a count queued behind it, so input holds
   `SML_ASSERT_IMPL(a_pending_blocks_input, clock, reset, rsp_channel.valid && (rsp_channel.result_kind == RESULT_MATCH) && !rsp_channel.last_of_run, !req_channel.ready, "input open while a count result waits")

endmodule
